>>> hw/rtl/jvm_pkg.sv
package jvm_pkg;

    localparam int STACK_DEPTH  = 256;
    localparam int LOCALS_COUNT = 256;
    localparam int SLOT_WIDTH   = 32;
    localparam int PC_WIDTH     = 16;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int LOC_W = $clog2(LOCALS_COUNT);

    // opcodes
    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_ICONST_M1 = 8'h02;
    localparam logic [7:0] OP_ICONST_0  = 8'h03;
    localparam logic [7:0] OP_ICONST_5  = 8'h08;
    localparam logic [7:0] OP_BIPUSH    = 8'h10;
    localparam logic [7:0] OP_SIPUSH    = 8'h11;
    localparam logic [7:0] OP_LDC       = 8'h12;
    localparam logic [7:0] OP_ILOAD     = 8'h15;
    localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
    localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
    localparam logic [7:0] OP_ISTORE    = 8'h36;
    localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
    localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
    localparam logic [7:0] OP_POP       = 8'h57;
    localparam logic [7:0] OP_DUP       = 8'h59;
    localparam logic [7:0] OP_IADD      = 8'h60;
    localparam logic [7:0] OP_ISUB      = 8'h64;
    localparam logic [7:0] OP_IMUL      = 8'h68;
    localparam logic [7:0] OP_IDIV      = 8'h6c;
    localparam logic [7:0] OP_IINC      = 8'h84;
    localparam logic [7:0] OP_IFEQ      = 8'h99;
    localparam logic [7:0] OP_IFLE      = 8'h9e;
    localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f;
    localparam logic [7:0] OP_IF_ICMPLE = 8'ha4;
    localparam logic [7:0] OP_GOTO      = 8'ha7;
    localparam logic [7:0] OP_IRETURN   = 8'hac;
    localparam logic [7:0] OP_RETURN    = 8'hb1;

    localparam logic CMD_EXEC  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_VRET     = 3'd1;
    localparam logic [2:0] ST_IRET     = 3'd2;
    localparam logic [2:0] ST_END      = 3'd3;
    localparam logic [2:0] ST_DIVZERO  = 3'd4;
    localparam logic [2:0] ST_BADOP    = 3'd5;
    localparam logic [2:0] ST_STKFAULT = 3'd6;
    localparam logic [2:0] ST_HALTED   = 3'd7;

    typedef struct packed {
        logic               command;
        logic [7:0]         opcode;
        logic [7:0]         operand_first;
        logic [7:0]         operand_second;
        logic signed [31:0] const_value;
    } jvm_in_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic [2:0]         status;
        logic signed [31:0] return_value;
    } jvm_out_t;

endpackage

>>> hw/rtl/jvm_stack.sv
module jvm_stack (
    input  logic                                 aclk,
    input  logic [jvm_pkg::SA_W-1:0]             rd0_addr,
    input  logic [jvm_pkg::SA_W-1:0]             rd1_addr,
    output logic [jvm_pkg::SLOT_WIDTH-1:0]       rd0_data,
    output logic [jvm_pkg::SLOT_WIDTH-1:0]       rd1_data,
    input  logic                                 wr_en,
    input  logic [jvm_pkg::SA_W-1:0]             wr_addr,
    input  logic [jvm_pkg::SLOT_WIDTH-1:0]       wr_data
);
    import jvm_pkg::*;

    logic [SLOT_WIDTH-1:0] mem [STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

>>> hw/rtl/jvm_locals.sv
module jvm_locals (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           clear,
    input  logic [jvm_pkg::LOC_W-1:0]      rd_addr,
    output logic [jvm_pkg::SLOT_WIDTH-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [jvm_pkg::LOC_W-1:0]      wr_addr,
    input  logic [jvm_pkg::SLOT_WIDTH-1:0] wr_data
);
    import jvm_pkg::*;

    logic [SLOT_WIDTH-1:0]   mem [LOCALS_COUNT];
    logic [LOCALS_COUNT-1:0] valid_reg;
    logic [SLOT_WIDTH-1:0]   rdata_reg;
    logic                    rvalid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // never-written slots read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

>>> hw/rtl/jvm_div.sv
module jvm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import jvm_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
        end else if (busy_reg) begin
            // one restoring step per cycle
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

>>> hw/rtl/jvm_integer_bytecode_core.sv
// Each item runs S_IDLE (accept), S_READ (memory read), S_EXEC (execute),
//   S_OUT (result valid); idiv waits in S_DIV on the bit-serial divider.
// One item in flight: the next item is accepted only after the result is
//   taken and the core has returned to S_IDLE.
// Reset (aresetn low, synchronous): stack pointer, pc, halt flag, code size
//   register and locals valid bits clear; operand stack contents stay undefined.
module jvm_integer_bytecode_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  jvm_pkg::jvm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output jvm_pkg::jvm_out_t m_data
);
    import jvm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT} state_t;

    state_t                state_reg, state_next;
    jvm_in_t               in_reg;
    jvm_out_t              out_reg, out_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    logic [PC_WIDTH-1:0]   pc_reg, pc_next;
    logic                  halted_reg, halted_next;
    logic [15:0]           code_len_reg;

    logic [SLOT_WIDTH-1:0] top0, top1, loc_rd;
    logic                  stk_we, loc_we, loc_clr, div_go, div_done;
    logic [SA_W-1:0]       stk_wa;
    logic [SLOT_WIDTH-1:0] stk_wd, loc_wd, div_q;
    logic [LOC_W-1:0]      loc_wa, loc_ra;
    logic [7:0]            op;
    logic [15:0]           off;
    logic [PC_WIDTH-1:0]   branch_pc;
    logic [SLOT_WIDTH-1:0] prod;
    logic [8:0]            idx;
    logic                  accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

    // locals read index from the captured item, read during S_READ
    always_comb begin
        if (in_reg.opcode == OP_ILOAD || in_reg.opcode == OP_IINC) begin
            loc_ra = LOC_W'(in_reg.operand_first);
        end else begin
            loc_ra = LOC_W'(in_reg.opcode - OP_ILOAD_0);
        end
    end

    jvm_stack u_stack (
        .aclk     (aclk),
        .rd0_addr (SA_W'(sp_reg - SP_W'(1))),
        .rd1_addr (SA_W'(sp_reg - SP_W'(2))),
        .rd0_data (top0),
        .rd1_data (top1),
        .wr_en    (stk_we),
        .wr_addr  (stk_wa),
        .wr_data  (stk_wd)
    );

    jvm_locals u_locals (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (loc_clr),
        .rd_addr (loc_ra),
        .rd_data (loc_rd),
        .wr_en   (loc_we),
        .wr_addr (loc_wa),
        .wr_data (loc_wd)
    );

    jvm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go),
        .dividend (top1),
        .divisor  (top0),
        .done     (div_done),
        .quotient (div_q)
    );

    function automatic logic cond_holds(input logic [2:0] sel, input logic [31:0] a,
                                        input logic [31:0] b);
        logic lt, gt;
        lt = $signed(a) < $signed(b);
        gt = $signed(b) < $signed(a);
        case (sel)
            3'd0:    cond_holds = (a == b);
            3'd1:    cond_holds = (a != b);
            3'd2:    cond_holds = lt;
            3'd3:    cond_holds = !lt;
            3'd4:    cond_holds = gt;
            default: cond_holds = !gt;
        endcase
    endfunction

    assign op        = in_reg.opcode;
    assign off       = {in_reg.operand_first, in_reg.operand_second};
    assign branch_pc = pc_reg + PC_WIDTH'(off);
    assign prod      = top1 * top0;

    always_comb begin
        logic [2:0]          st;
        logic [PC_WIDTH-1:0] npc;
        logic [31:0]         rv;
        logic                fin;

        state_next  = state_reg;
        out_next    = out_reg;
        sp_next     = sp_reg;
        pc_next     = pc_reg;
        halted_next = halted_reg;
        stk_we      = 1'b0;
        stk_wa      = SA_W'(sp_reg);
        stk_wd      = top0;
        loc_we      = 1'b0;
        loc_wa      = LOC_W'(in_reg.operand_first);
        loc_wd      = top0;
        loc_clr     = 1'b0;
        div_go      = 1'b0;
        st          = ST_RUN;
        npc         = pc_reg;
        rv          = '0;
        fin         = 1'b0;
        idx         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                fin = 1'b1;
                if (in_reg.command == CMD_START) begin
                    loc_clr     = 1'b1;
                    sp_next     = '0;
                    pc_next     = '0;
                    halted_next = (code_len_reg == 16'd0);
                    out_next    = '{next_pc: 16'd0,
                                    status: halted_next ? ST_END : ST_RUN,
                                    return_value: '0};
                    fin         = 1'b0;
                    state_next  = S_OUT;
                end else if (halted_reg) begin
                    st = ST_HALTED;
                end else if (16'(pc_reg) >= code_len_reg) begin
                    st = ST_END;
                end else begin
                    case (op) inside
                        OP_NOP: npc = pc_reg + PC_WIDTH'(1);
                        [OP_ICONST_M1:OP_ICONST_5], OP_BIPUSH, OP_SIPUSH, OP_LDC: begin
                            if (sp_reg >= SP_W'(STACK_DEPTH)) begin
                                st = ST_STKFAULT;
                            end else begin
                                stk_we  = 1'b1;
                                sp_next = sp_reg + SP_W'(1);
                                if (op == OP_BIPUSH) begin
                                    stk_wd = {{24{in_reg.operand_first[7]}},
                                              in_reg.operand_first};
                                    npc    = pc_reg + PC_WIDTH'(2);
                                end else if (op == OP_SIPUSH) begin
                                    stk_wd = {{16{off[15]}}, off};
                                    npc    = pc_reg + PC_WIDTH'(3);
                                end else if (op == OP_LDC) begin
                                    stk_wd = in_reg.const_value;
                                    npc    = pc_reg + PC_WIDTH'(2);
                                end else begin
                                    stk_wd = {24'd0, op} - 32'd3;
                                    npc    = pc_reg + PC_WIDTH'(1);
                                end
                            end
                        end
                        OP_ILOAD, [OP_ILOAD_0:OP_ILOAD_3]: begin
                            idx = (op == OP_ILOAD) ? {1'b0, in_reg.operand_first}
                                                   : {1'b0, op - OP_ILOAD_0};
                            if (sp_reg >= SP_W'(STACK_DEPTH) || idx >= 9'(LOCALS_COUNT)) begin
                                st = ST_STKFAULT;
                            end else begin
                                stk_we  = 1'b1;
                                stk_wd  = loc_rd;
                                sp_next = sp_reg + SP_W'(1);
                                npc     = pc_reg + PC_WIDTH'((op == OP_ILOAD) ? 2 : 1);
                            end
                        end
                        OP_ISTORE, [OP_ISTORE_0:OP_ISTORE_3]: begin
                            idx = (op == OP_ISTORE) ? {1'b0, in_reg.operand_first}
                                                    : {1'b0, op - OP_ISTORE_0};
                            if (sp_reg < SP_W'(1) || idx >= 9'(LOCALS_COUNT)) begin
                                st = ST_STKFAULT;
                            end else begin
                                loc_we  = 1'b1;
                                loc_wa  = LOC_W'(idx);
                                sp_next = sp_reg - SP_W'(1);
                                npc     = pc_reg + PC_WIDTH'((op == OP_ISTORE) ? 2 : 1);
                            end
                        end
                        OP_POP: begin
                            if (sp_reg < SP_W'(1)) begin
                                st = ST_STKFAULT;
                            end else begin
                                sp_next = sp_reg - SP_W'(1);
                                npc     = pc_reg + PC_WIDTH'(1);
                            end
                        end
                        OP_DUP: begin
                            if (sp_reg < SP_W'(1) || sp_reg >= SP_W'(STACK_DEPTH)) begin
                                st = ST_STKFAULT;
                            end else begin
                                stk_we  = 1'b1;
                                sp_next = sp_reg + SP_W'(1);
                                npc     = pc_reg + PC_WIDTH'(1);
                            end
                        end
                        OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV: begin
                            if (sp_reg < SP_W'(2)) begin
                                st = ST_STKFAULT;
                            end else if (op == OP_IDIV) begin
                                if (top0 == '0) begin
                                    st = ST_DIVZERO;
                                end else begin
                                    div_go     = 1'b1;
                                    fin        = 1'b0;
                                    state_next = S_DIV;
                                end
                            end else begin
                                stk_we  = 1'b1;
                                stk_wa  = SA_W'(sp_reg - SP_W'(2));
                                stk_wd  = (op == OP_IADD) ? top1 + top0 :
                                          (op == OP_ISUB) ? top1 - top0 : prod;
                                sp_next = sp_reg - SP_W'(1);
                                npc     = pc_reg + PC_WIDTH'(1);
                            end
                        end
                        OP_IINC: begin
                            if ({1'b0, in_reg.operand_first} >= 9'(LOCALS_COUNT)) begin
                                st = ST_STKFAULT;
                            end else begin
                                loc_we = 1'b1;
                                loc_wd = loc_rd + {{24{in_reg.operand_second[7]}},
                                                   in_reg.operand_second};
                                npc    = pc_reg + PC_WIDTH'(3);
                            end
                        end
                        [OP_IFEQ:OP_IFLE]: begin
                            if (sp_reg < SP_W'(1)) begin
                                st = ST_STKFAULT;
                            end else begin
                                sp_next = sp_reg - SP_W'(1);
                                npc = cond_holds(3'(op - OP_IFEQ), top0, 32'd0)
                                      ? branch_pc : pc_reg + PC_WIDTH'(3);
                            end
                        end
                        [OP_IF_ICMPEQ:OP_IF_ICMPLE]: begin
                            if (sp_reg < SP_W'(2)) begin
                                st = ST_STKFAULT;
                            end else begin
                                sp_next = sp_reg - SP_W'(2);
                                npc = cond_holds(3'(op - OP_IF_ICMPEQ), top1, top0)
                                      ? branch_pc : pc_reg + PC_WIDTH'(3);
                            end
                        end
                        OP_GOTO: npc = branch_pc;
                        OP_IRETURN: begin
                            if (sp_reg < SP_W'(1)) begin
                                st = ST_STKFAULT;
                            end else begin
                                st = ST_IRET;
                                rv = top0;
                            end
                        end
                        OP_RETURN: st = ST_VRET;
                        default:   st = ST_BADOP;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    fin     = 1'b1;
                    stk_we  = 1'b1;
                    stk_wa  = SA_W'(sp_reg - SP_W'(2));
                    stk_wd  = div_q;
                    sp_next = sp_reg - SP_W'(1);
                    npc     = pc_reg + PC_WIDTH'(1);
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (fin) begin
            state_next = S_OUT;
            if (st != ST_RUN) begin
                // any status other than ST_RUN (fault, return, end) leaves the frame untouched
                stk_we   = 1'b0;
                loc_we   = 1'b0;
                sp_next  = sp_reg;
                if (st != ST_HALTED) begin
                    halted_next = 1'b1;
                end
                out_next = '{next_pc: 16'(pc_reg), status: st, return_value: rv};
            end else begin
                pc_next  = npc;
                if (16'(npc) >= code_len_reg) begin
                    halted_next = 1'b1;
                    st          = ST_END;
                end
                out_next = '{next_pc: 16'(npc), status: st, return_value: '0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            pc_reg       <= '0;
            halted_reg   <= 1'b0;
            code_len_reg <= '0;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            pc_reg     <= pc_next;
            halted_reg <= halted_next;
            if (cfg_wr_en) begin
                code_len_reg <= cfg_wr_data;
            end
        end
        out_reg <= out_next;
        if (accept) begin
            in_reg <= s_data;
        end
    end

endmodule

>>> hw/rtl/jvm_checker.sv
module jvm_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input jvm_pkg::jvm_out_t m_data
);
    import jvm_pkg::*;

    // one item in flight: no new item while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready && !m_valid)
        else $error("accept not followed by busy cycle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_void_ret_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_IRET) |-> m_data.return_value == '0)
        else $error("return value set without ireturn");

endmodule

bind jvm_integer_bytecode_core jvm_checker u_jvm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
